// ===== hw/rtl/smrm_pkg.sv =====
// ----------------------------------------------------------------------------
// smrm_pkg
// Types and constants shared by the stem mixer, router and meter block.
// ----------------------------------------------------------------------------
package smrm_pkg;

    localparam int NUM_TRACKS      = 16;
    localparam int OUT_CHANNEL_MAX = 8;
    localparam int TRACK_W         = 4;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [16:0] FADER_MAX   = 17'd65536;
    localparam logic [15:0] UNITY_Q15   = 16'd32768;
    localparam logic [15:0] PAN_Q15     = 16'd23170;
    localparam logic [15:0] CLICK_Q15   = 16'd29491;
    localparam logic [15:0] TRIM_Q15    = 16'd30147;
    localparam logic [15:0] DECAY_AUD   = 16'd30802;
    localparam logic [15:0] DECAY_SIL   = 16'd30147;
    localparam logic [25:0] METER_CLAMP = 26'd12582912;

    localparam logic [0:0] REG_MASTER_GAIN  = 1'b0;
    localparam logic [0:0] REG_OUT_CHANNELS = 1'b1;

    typedef struct packed {
        logic [3:0]         track;
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic [16:0]        fader_gain;
        logic               is_guide;
        logic               is_click;
        logic               muted;
        logic               soloed;
        logic               any_solo;
        logic [1:0]         out_pair;
        logic               frame_last;
        logic               block_last;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         meter_track;
        logic [23:0]        meter_level;
        logic               meter_valid;
        logic               frame_valid;
        logic signed [23:0] out_ch0;
        logic signed [23:0] out_ch1;
        logic signed [23:0] out_ch2;
        logic signed [23:0] out_ch3;
        logic signed [23:0] out_ch4;
        logic signed [23:0] out_ch5;
        logic signed [23:0] out_ch6;
        logic signed [23:0] out_ch7;
    } t_out_item;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [3:0]         track;
        logic               audible;
        logic               guide;
        logic signed [24:0] sa;      // left, or left+right for guide
        logic signed [23:0] sb;      // right
        logic [16:0]        gain;    // saturated fader gain
        logic [15:0]        coef;
        logic [1:0]         pair;
        logic               frame_last;
        logic               block_last;
    } t_req;

    function automatic logic signed [47:0] round_shr(input logic signed [63:0] v,
                                                     input int sh);
        logic [63:0] mag;
        logic [63:0] r;
        begin
            mag = v[63] ? (64'd0 - v) : v;
            r   = (mag + (64'd1 << (sh - 1))) >> sh;
            round_shr = v[63] ? 48'(64'd0 - r) : 48'(r);
        end
    endfunction

endpackage

// ===== hw/rtl/smrm_front.sv =====
// ----------------------------------------------------------------------------
// smrm_front
// Accepts track samples, classifies them and pushes requests into a queue.
// ----------------------------------------------------------------------------
module smrm_front
    import smrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_q_valid,
    input  logic     i_q_pop,
    output t_req     o_q_head
);

    t_req       r_q [QUEUE_DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    t_req       w_req;
    logic       w_push;

    always_comb begin
        w_req            = '0;
        w_req.track      = i_item.track;
        w_req.audible    = !i_item.muted && (!i_item.any_solo || i_item.soloed);
        w_req.guide      = i_item.is_guide;
        w_req.gain       = (i_item.fader_gain > FADER_MAX) ? FADER_MAX : i_item.fader_gain;
        w_req.pair       = i_item.out_pair;
        w_req.frame_last = i_item.frame_last;
        w_req.block_last = i_item.block_last;
        if (i_item.is_guide) begin
            w_req.sa   = 25'(i_item.left_sample) + 25'(i_item.right_sample);
            w_req.sb   = '0;
            w_req.coef = i_item.is_click ? CLICK_Q15 : UNITY_Q15;
        end else begin
            w_req.sa   = 25'(i_item.left_sample);
            w_req.sb   = i_item.right_sample;
            w_req.coef = PAN_Q15;
        end
    end

    assign o_ready   = (r_cnt != 3'(QUEUE_DEPTH));
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 3'd0);
    assign o_q_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(w_push) - 3'(i_q_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_q_pop) |=> r_cnt == $past(r_cnt) + 3'd1) else $error("count");
`endif

endmodule

// ===== hw/rtl/smrm_back.sv =====
// ----------------------------------------------------------------------------
// smrm_back
// Sequencer that mixes, routes, meters and emits one request at a time.
// ----------------------------------------------------------------------------
module smrm_back
    import smrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_req        i_req,
    input  logic [15:0] i_master_gain,
    input  logic [3:0]  i_out_channels,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL1  = 6'b000010,
        S_MUL2  = 6'b000100,
        S_ROUTE = 6'b001000,
        S_OUTM  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_req   r_req;
    logic signed [42:0] r_pa, r_pb;         // sample*gain
    logic signed [47:0] r_l, r_r;           // rounded contributions
    logic signed [31:0] r_acc [OUT_CHANNEL_MAX];
    logic [25:0] r_peak  [NUM_TRACKS];
    logic [23:0] r_meter [NUM_TRACKS];
    logic [2:0]  r_ch;
    logic signed [47:0] r_trim;             // acc*trim
    logic signed [23:0] r_outs [OUT_CHANNEL_MAX];
    logic [23:0] r_mlevel;
    t_out_item   r_out;
    logic        r_ovalid;

    logic [3:0]  w_n;
    logic [15:0] w_mg;
    logic signed [63:0] w_la, w_ra, w_om;
    logic signed [47:0] w_lr, w_rr, w_ov;
    logic [47:0] w_lm, w_rm, w_pk;
    logic [25:0] w_pk26, w_newpk, w_dd, w_m;
    logic signed [31:0] w_add [OUT_CHANNEL_MAX];
    logic [2:0]  w_maxp, w_p;
    t_out_item   w_out;

    assign w_n  = (i_out_channels > 4'(OUT_CHANNEL_MAX)) ? 4'(OUT_CHANNEL_MAX) : i_out_channels;
    assign w_mg = (i_master_gain > UNITY_Q15) ? UNITY_Q15 : i_master_gain;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // Second product stage, rounding, routing, master gain and meter levels.
    always_comb begin
        w_la = 64'(r_pa) * $signed({48'd0, r_req.coef});
        w_ra = 64'(r_pb) * $signed({48'd0, r_req.coef});
        w_lr = r_req.guide ? round_shr(w_la, 30) : round_shr(w_la, 29);
        w_rr = r_req.guide ? 48'sd0 : round_shr(w_ra, 29);
        w_om = 64'(r_trim) * $signed({48'd0, w_mg});
        w_ov = round_shr(w_om, 30);
        w_lm = r_l[47] ? 48'd0 - r_l : r_l;
        w_rm = r_r[47] ? 48'd0 - r_r : r_r;
        w_pk = (w_rm > w_lm) ? w_rm : w_lm;
        w_pk26 = w_pk[25:0];
        w_newpk = (w_pk26 > r_peak[r_req.track]) ? w_pk26 : r_peak[r_req.track];
        if (!r_req.audible) begin
            w_newpk = r_peak[r_req.track];
        end
        w_maxp = 3'(w_n >> 1) - 3'd1;
        w_p    = (3'(r_req.pair) > w_maxp) ? w_maxp : 3'(r_req.pair);
        for (int c = 0; c < OUT_CHANNEL_MAX; c++) begin
            w_add[c] = '0;
        end
        if (r_req.audible) begin
            if (w_n == 4'd1) begin
                w_add[0] = 32'(round_shr(64'(r_l + r_r), 1));
            end else if (w_n == 4'd2) begin
                w_add[0] = r_l[31:0];
                w_add[1] = r_r[31:0];
            end else if (w_n >= 4'd3) begin
                if ({w_p, 1'b1} < w_n) begin
                    w_add[{w_p[1:0], 1'b0}] = r_l[31:0];
                    w_add[{w_p[1:0], 1'b1}] = r_r[31:0];
                end
            end
        end
        w_dd = 26'((({26'd0, r_meter[r_req.track]} * (r_req.audible ? DECAY_AUD : DECAY_SIL))
                   + 42'd16384) >> 15);
        if (r_req.audible) begin
            w_m = (w_newpk > w_dd) ? w_newpk : w_dd;
            if (w_m > METER_CLAMP) begin
                w_m = METER_CLAMP;
            end
        end else begin
            w_m = w_dd;
        end
    end

    // Result assembled from the meter level and the finished channels.
    always_comb begin
        w_out = '0;
        if (r_req.block_last) begin
            w_out.meter_track = r_req.track;
            w_out.meter_level = r_mlevel;
            w_out.meter_valid = 1'b1;
        end
        if (r_req.frame_last) begin
            w_out.frame_valid = 1'b1;
            w_out.out_ch0 = (w_n > 4'd0) ? r_outs[0] : '0;
            w_out.out_ch1 = (w_n > 4'd1) ? r_outs[1] : '0;
            w_out.out_ch2 = (w_n > 4'd2) ? r_outs[2] : '0;
            w_out.out_ch3 = (w_n > 4'd3) ? r_outs[3] : '0;
            w_out.out_ch4 = (w_n > 4'd4) ? r_outs[4] : '0;
            w_out.out_ch5 = (w_n > 4'd5) ? r_outs[5] : '0;
            w_out.out_ch6 = (w_n > 4'd6) ? r_outs[6] : '0;
            w_out.out_ch7 = (w_n > 4'd7) ? r_outs[7] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    r_req <= i_req;
                end
            end
            S_MUL1: begin
                r_pa <= 43'(r_req.sa) * $signed({26'd0, r_req.gain});
                r_pb <= 43'(r_req.sb) * $signed({26'd0, r_req.gain});
            end
            S_MUL2: begin
                r_l <= w_lr;
                r_r <= w_rr;
            end
            S_ROUTE: begin
                // Channel 0 must include the contribution added at this edge.
                r_trim   <= 48'(r_acc[0] + w_add[0]) * $signed({32'd0, TRIM_Q15});
                r_mlevel <= w_m[23:0];
            end
            S_OUTM: begin
                r_outs[r_ch] <= (w_ov > 48'sd8388607) ? 24'sh7FFFFF :
                                (w_ov < -48'sd8388608) ? -24'sh800000 : w_ov[23:0];
                r_trim <= 48'(r_acc[3'(r_ch + 3'd1)]) * $signed({32'd0, TRIM_Q15});
            end
            default: begin
            end
        endcase
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ch     <= '0;
            for (int c = 0; c < OUT_CHANNEL_MAX; c++) r_acc[c] <= '0;
            for (int t = 0; t < NUM_TRACKS; t++) begin
                r_peak[t]  <= '0;
                r_meter[t] <= '0;
            end
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_ROUTE;
                S_ROUTE: begin
                    for (int c = 0; c < OUT_CHANNEL_MAX; c++) begin
                        r_acc[c] <= r_acc[c] + w_add[c];
                    end
                    r_peak[r_req.track] <= r_req.block_last ? 26'd0 : w_newpk;
                    if (r_req.block_last) begin
                        r_meter[r_req.track] <= w_m[23:0];
                    end
                    r_ch <= '0;
                    if (r_req.frame_last) begin
                        r_state <= S_OUTM;
                        for (int c = 0; c < OUT_CHANNEL_MAX; c++) r_outs[c] <= '0;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_OUTM: begin
                    if (r_ch == 3'(OUT_CHANNEL_MAX - 1)) begin
                        r_state <= S_DONE;
                    end
                    r_ch <= r_ch + 3'd1;
                end
                S_DONE: begin
                    if (r_req.frame_last) begin
                        for (int c = 0; c < OUT_CHANNEL_MAX; c++) r_acc[c] <= '0;
                    end
                    r_out    <= w_out;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == S_MUL1) else $error("pop outside idle");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_ovalid) else $error("result not emitted");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
`endif

endmodule

// ===== hw/rtl/stem_mixer_router_meter.sv =====
// ----------------------------------------------------------------------------
// stem_mixer_router_meter
// Stem channel strip, output router and per-track peak meter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one track sample request per frame
//   slot. Each request yields exactly one result on o_valid/i_ready, carrying
//   the meter update (on block end) and the mixed frame (on frame end).
//   A front end classifies requests into a four-entry queue; a back-end
//   sequencer performs two multiply stages, routing and metering.
//   A frame-ending request also passes the eight output channels through
//   one trim/master multiplier, one channel a cycle. The sequencer takes a
//   new request only when idle, once its last result is in the output register.
//   A result that waits in the output register holds the sequencer idle
//   until it is taken. While the receiver stalls the queue fills, then
//   o_ready falls. Reset clears accumulators, peaks and meters at once and
//   loads master gain unity and two output channels.
// ----------------------------------------------------------------------------
module stem_mixer_router_meter
    import smrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_master_gain;
    logic [3:0]  r_out_channels;
    logic        w_qv, w_pop;
    t_req        w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_gain  <= UNITY_Q15;
            r_out_channels <= 4'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MASTER_GAIN) begin
                r_master_gain <= i_cfg_data;
            end else begin
                r_out_channels <= i_cfg_data[3:0];
            end
        end
    end

    smrm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_head(w_head)
    );

    smrm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_req(w_head), .i_master_gain(r_master_gain),
        .i_out_channels(r_out_channels), .o_valid(o_valid), .i_ready(i_ready),
        .o_item(o_item)
    );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stem mixer, router and peak meter. Random
// frames and blocks of track requests are driven at varying pressure.
// Every result is compared with a bit-exact model of the gain, routing,
// master-trim and meter arithmetic, across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import smrm_pkg::*;

    localparam longint TRIM = 30147;
    localparam longint PAN = 23170;
    localparam longint CLICK = 29491;
    localparam longint UNITY = 32768;
    localparam longint DEC_AUD = 30802;
    localparam longint DEC_SIL = 30147;
    localparam longint CLAMP = 12582912;

    class mix_scoreboard;
        bit [15:0] master_gain;
        bit [3:0]  out_channels;
        bit [31:0] acc [8];
        bit [25:0] peak [16];
        bit [23:0] meter [16];
        t_out_item pending_results [$];
        int        errors;

        function new();
            master_gain = 16'd32768;
            out_channels = 4'd2;
            foreach (acc[i]) acc[i] = '0;
            foreach (peak[i]) peak[i] = '0;
            foreach (meter[i]) meter[i] = '0;
            errors = 0;
        endfunction

        function longint rnd_shift(longint v, int sh);
            longint unsigned mag;
            longint unsigned half;
            half = 64'd1 << (sh - 1);
            if (v < 0) begin
                mag = 64'd0 - v;
                return -longint'((mag + half) >> sh);
            end
            return longint'((longint'(v) + half) >> sh);
        endfunction

        function bit [23:0] decay(bit [23:0] m, longint coef);
            longint unsigned p;
            p = (longint'(m) * coef + 16384) >> 15;
            return p[23:0];
        endfunction

        function void add_channel(int c, longint v);
            acc[c] = acc[c] + v[31:0];
        endfunction

        function void set_reg(bit idx, bit [15:0] data);
            if (idx == REG_MASTER_GAIN)
                master_gain = data;
            else
                out_channels = data[3:0];
        endfunction

        function void note_request(t_in_item it);
            longint ls, rs, gain, l, r, coef, pk, mg, v;
            int n, maxp, p;
            bit audible;
            bit [25:0] m;
            t_out_item res;
            logic [23:0] ch [8];
            ls = longint'(it.left_sample);
            rs = longint'(it.right_sample);
            gain = (it.fader_gain > FADER_MAX) ? 65536 : longint'(it.fader_gain);
            audible = !it.muted && (!it.any_solo || it.soloed);
            n = (out_channels > 8) ? 8 : out_channels;
            res = '0;
            foreach (ch[i]) ch[i] = '0;
            if (audible) begin
                if (it.is_guide) begin
                    coef = it.is_click ? CLICK : UNITY;
                    l = rnd_shift((ls + rs) * gain * coef, 30);
                    r = 0;
                end else begin
                    l = rnd_shift(ls * gain * PAN, 29);
                    r = rnd_shift(rs * gain * PAN, 29);
                end
                if (n == 1) begin
                    add_channel(0, rnd_shift(l + r, 1));
                end else if (n == 2) begin
                    add_channel(0, l);
                    add_channel(1, r);
                end else if (n >= 3) begin
                    maxp = n / 2 - 1;
                    p = (it.out_pair > maxp) ? maxp : it.out_pair;
                    if (2 * p + 1 < n) begin
                        add_channel(2 * p, l);
                        add_channel(2 * p + 1, r);
                    end
                end
                pk = (l < 0) ? -l : l;
                if (((r < 0) ? -r : r) > pk) pk = (r < 0) ? -r : r;
                if (pk > longint'(peak[it.track])) peak[it.track] = pk[25:0];
            end
            if (it.block_last) begin
                if (audible) begin
                    m = {2'b00, decay(meter[it.track], DEC_AUD)};
                    if (peak[it.track] > m) m = peak[it.track];
                    if (m > CLAMP) m = CLAMP;
                end else begin
                    m = {2'b00, decay(meter[it.track], DEC_SIL)};
                end
                meter[it.track] = m[23:0];
                peak[it.track] = '0;
                res.meter_track = it.track;
                res.meter_level = m[23:0];
                res.meter_valid = 1'b1;
            end
            if (it.frame_last) begin
                mg = (master_gain > 16'd32768) ? 32768 : longint'(master_gain);
                for (int c = 0; c < n; c++) begin
                    v = rnd_shift(longint'(signed'(acc[c])) * TRIM * mg, 30);
                    if (v > 8388607) v = 8388607;
                    if (v < -8388608) v = -8388608;
                    ch[c] = v[23:0];
                end
                foreach (acc[i]) acc[i] = '0;
                res.frame_valid = 1'b1;
            end
            {res.out_ch0, res.out_ch1, res.out_ch2, res.out_ch3,
             res.out_ch4, res.out_ch5, res.out_ch6, res.out_ch7} =
                {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], ch[6], ch[7]};
            pending_results.insert(pending_results.size(), res);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item exp;
            logic [23:0] g [8];
            logic [23:0] e [8];
            if (pending_results.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            exp = pending_results.pop_front();
            if (got.meter_valid !== exp.meter_valid)
                report($sformatf("meter_valid got %0d exp %0d", got.meter_valid,
                                 exp.meter_valid));
            if (got.meter_track !== exp.meter_track)
                report($sformatf("meter_track got %0d exp %0d", got.meter_track,
                                 exp.meter_track));
            if (got.meter_level !== exp.meter_level)
                report($sformatf("meter_level got %0d exp %0d", got.meter_level,
                                 exp.meter_level));
            if (got.frame_valid !== exp.frame_valid)
                report($sformatf("frame_valid got %0d exp %0d", got.frame_valid,
                                 exp.frame_valid));
            {g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7]} =
                {got.out_ch0, got.out_ch1, got.out_ch2, got.out_ch3,
                 got.out_ch4, got.out_ch5, got.out_ch6, got.out_ch7};
            {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7]} =
                {exp.out_ch0, exp.out_ch1, exp.out_ch2, exp.out_ch3,
                 exp.out_ch4, exp.out_ch5, exp.out_ch6, exp.out_ch7};
            for (int c = 0; c < 8; c++)
                if (g[c] !== e[c])
                    report($sformatf("out_ch%0d got %0d exp %0d", c,
                                     $signed(g[c]), $signed(e[c])));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_item    i_item = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_item;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    mix_scoreboard mix_sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_request = 0;

    stem_mixer_router_meter uut (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready)
            mix_sb.check_result(o_item);

    task automatic send_request(t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        mix_sb.note_request(it);
    endtask

    task automatic wait_drained();
        while (mix_sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(bit [15:0] gain, bit [3:0] chans);
        i_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_MASTER_GAIN;
        i_cfg_data <= gain;
        @(posedge i_clk);
        mix_sb.set_reg(REG_MASTER_GAIN, gain);
        i_cfg_index <= REG_OUT_CHANNELS;
        i_cfg_data <= {12'd0, chans};
        @(posedge i_clk);
        mix_sb.set_reg(REG_OUT_CHANNELS, {12'd0, chans});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(7))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'(signed'($urandom_range(15)) - 8);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_request(bit f_last, bit b_last);
        t_in_item it;
        it = '0;
        it.is_guide = 1'($urandom_range(1));
        it.is_click = 1'($urandom_range(1));
        it.soloed = 1'($urandom_range(1));
        it.out_pair = 2'($urandom_range(3));
        it.track = 4'($urandom_range(15));
        it.left_sample = pick_sample();
        it.right_sample = ($urandom_range(3) == 0) ? it.left_sample : pick_sample();
        case ($urandom_range(9))
            0: it.fader_gain = 17'd65536;
            1: it.fader_gain = 17'($urandom_range(131071, 65537));
            2: it.fader_gain = '0;
            default: it.fader_gain = 17'($urandom_range(65536));
        endcase
        it.muted = ($urandom_range(5) == 0);
        it.any_solo = ($urandom_range(3) == 0);
        it.frame_last = f_last;
        it.block_last = b_last;
        return it;
    endfunction

    // Sends one block: one to four frames, the last of which updates meters.
    task automatic send_block(output int count);
        int frames, len;
        bit blk;
        count = 0;
        frames = $urandom_range(4, 1);
        for (int f = 0; f < frames; f++) begin
            len = ($urandom_range(24) == 0) ? $urandom_range(90, 40)
                                            : $urandom_range(6, 1);
            blk = (f == frames - 1);
            for (int k = 0; k < len; k++) begin
                send_request(make_request(k == len - 1, blk));
                count++;
            end
        end
    endtask

    task automatic run_directed();
        t_in_item it;
        for (int k = 0; k < 22; k++) begin
            it = '0;
            it.track = k[3:0];
            it.fader_gain = 17'd16384;
            it.left_sample = 24'sh7FFFFF;
            it.right_sample = 24'sh800000;
            case (k)
                1: it.fader_gain = 17'd65536;
                2: it.fader_gain = 17'h1FFFF;
                3: it.fader_gain = 17'd0;
                4: it.is_guide = 1'b1;
                5: {it.is_guide, it.is_click} = 2'b11;
                6: it.is_click = 1'b1;
                7: it.muted = 1'b1;
                8: {it.any_solo, it.soloed} = 2'b11;
                9: it.any_solo = 1'b1;
                10: {it.muted, it.soloed, it.any_solo} = 3'b111;
                11: it.out_pair = 2'd3;
                12: it.left_sample = 24'sh800000;
                13: it.right_sample = 24'sh7FFFFF;
                14: {it.left_sample, it.right_sample} = '0;
                default: it = make_request(1'b0, 1'b0);
            endcase
            it.frame_last = (k % 3 == 2) || (k == 21);
            it.block_last = (k >= 16);
            send_request(it);
        end
    endtask

    initial begin
        bit [15:0] gains [10] = '{16'd32768, 16'd0, 16'hFFFF, 16'd20000, 16'd32768,
                                  16'd12345, 16'd40000, 16'd32768, 16'd1, 16'd30000};
        bit [3:0]  chans [10] = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd3, 4'd15, 4'd5, 4'd4,
                                  4'd6, 4'd7};
        int sent;
        int cnt;
        bit paused;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int ph = 0; ph < 10; ph++) begin
            write_regs(gains[ph], chans[ph]);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
                default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
            endcase
            if (ph == 0 || ph == 5) hold_request = 300;
            sent = 0;
            paused = 1'b0;
            while (sent < 155) begin
                if (!paused && sent > 80) begin
                    i_valid <= 1'b0;
                    wait_drained();
                    @(posedge i_clk);
                    paused = 1'b1;
                end
                send_block(cnt);
                sent = sent + cnt;
            end
        end
        i_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mix_sb.errors == 0 && mix_sb.pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
